// ----- design/lle_pkg.sv -----
// Shared types and command codes for the linked list engine.
package lle_pkg;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_TAIL  = 3'd1,
        CMD_INS_AFTER = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_TAIL  = 3'd4,
        CMD_DEL_KEY   = 3'd5,
        CMD_READ_OUT  = 3'd6,
        CMD_UNUSED    = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_SPARE = 2'd3
    } status_t;

    localparam int MAX_OUT = 32;

endpackage

// ----- design/lle_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module lle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/lle_alloc.sv -----
// Free bitmap with lowest-free-node search and node release.
module lle_alloc #(
    parameter int CAPACITY = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic                        give,
    input  logic [$clog2(CAPACITY)-1:0] give_idx,
    output logic                        any_free,
    output logic [$clog2(CAPACITY)-1:0] free_idx
);
    localparam int IW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] free_reg;
    logic [CAPACITY-1:0] free_next;

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                free_idx = IW'(i);
            end
        end
        any_free = |free_reg;
    end

    always_comb begin
        free_next = free_reg;
        if (take) begin
            free_next[free_idx] = 1'b0;
        end
        if (give) begin
            free_next[give_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= '1;
        end else begin
            free_reg <= free_next;
        end
    end

    no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> any_free) else $error("node taken from a full pool");
endmodule

// ----- design/linked_list_engine.sv -----
// Linked list engine top level: sequencer walking a node pool held in RAMs.
//
//  channel | dir | tdata (low bit up)          | tuser  | tlast
//  s_      | in  | cmd[2:0] value[34:3] key[66:35] | -   | -
//  m_      | out | status[1:0] item[33:2]      | -      | last
//
//  With m_ always ready: insert front and insert tail on an empty list go
//  from S_RD straight to S_OUT; delete front passes S_WAIT and S_EVAL first.
//  Tail and key walks pass S_WAIT and S_EVAL for each visited node (one RAM
//  read plus its register) until a nil link or the step bound ends the walk.
//  Read out passes S_EMIT, S_WR2 and S_EVAL per word, at most 32 words.
//  Reset empties the list at once; no clearing pass is needed.
//  s_axis_tready is low from acceptance until the last result word is taken;
//  a stalled m_ side holds the sequencer.
module linked_list_engine #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // cmd[2:0], value[34:3], key[66:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[1:0], item[33:2]
    output logic        m_axis_tlast
);
    import lle_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = $clog2(MAX_OUT + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,
        S_WAIT  = 8'b00000100,
        S_EVAL  = 8'b00001000,
        S_WR1   = 8'b00010000,
        S_WR2   = 8'b00100000,
        S_EMIT  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [VALUE_BITS-1:0] val_reg, key_reg;
    logic [IW-1:0]         head_reg, cur_reg, prev_reg, new_reg;
    logic                  head_nil_reg, prev_nil_reg;
    logic [CW-1:0]         steps_reg;
    logic [RW-1:0]         cnt_reg;
    logic [1:0]            st_reg;
    logic [31:0]           item_reg;
    logic                  last_reg, ovalid_reg;

    // RAM ports
    logic                  v_we, l_we;
    logic [IW-1:0]         v_wa, l_wa, rd_a;
    logic [VALUE_BITS-1:0] v_wd, v_rd;
    logic [IW:0]           l_wd, l_rd;
    logic                  l_nil;
    logic [IW-1:0]         l_nxt;

    lle_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
        .aclk(aclk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
        .raddr(rd_a), .rdata(v_rd));
    lle_ram #(.WIDTH(IW + 1), .DEPTH(CAPACITY)) u_link (
        .aclk(aclk), .we(l_we), .waddr(l_wa), .wdata(l_wd),
        .raddr(rd_a), .rdata(l_rd));

    assign l_nil = l_rd[IW];
    assign l_nxt = l_rd[IW-1:0];

    logic          a_take, a_give, a_any;
    logic [IW-1:0] a_gidx, a_fidx;

    lle_alloc #(.CAPACITY(CAPACITY)) u_alloc (
        .aclk(aclk), .aresetn(aresetn), .take(a_take), .give(a_give),
        .give_idx(a_gidx), .any_free(a_any), .free_idx(a_fidx));

    logic       acc, out_fire, hit, walk_end;
    logic [1:0] st_set;
    logic       do_out;

    assign acc      = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign hit      = (v_rd == key_reg);
    assign walk_end = (steps_reg >= CW'(CAPACITY - 1));

    // sequencer
    logic [IW-1:0] cur_n, prev_n, head_n, new_n;
    logic          head_nil_n, prev_nil_n;
    logic [CW-1:0] steps_n;
    logic [RW-1:0] cnt_n;

    always_comb begin
        state_next = state_reg;
        cur_n = cur_reg; prev_n = prev_reg; head_n = head_reg; new_n = new_reg;
        head_nil_n = head_nil_reg; prev_nil_n = prev_nil_reg;
        steps_n = steps_reg; cnt_n = cnt_reg;
        v_we = 1'b0; v_wa = new_reg; v_wd = val_reg;
        l_we = 1'b0; l_wa = new_reg; l_wd = '0;
        rd_a = cur_reg;
        a_take = 1'b0; a_give = 1'b0; a_gidx = cur_reg;
        do_out = 1'b0; st_set = ST_DONE;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    cur_n = head_reg; prev_nil_n = 1'b1;
                    steps_n = '0; cnt_n = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                // decide per command, issue first read
                state_next = S_WAIT;
                case (cmd_reg)
                    CMD_INS_FRONT, CMD_INS_TAIL: begin
                        if (!a_any) begin
                            do_out = 1'b1; st_set = ST_FULL; state_next = S_OUT;
                        end else begin
                            a_take = 1'b1; new_n = a_fidx;
                            v_we = 1'b1; v_wa = a_fidx; l_we = 1'b1; l_wa = a_fidx;
                            if (cmd_reg == CMD_INS_FRONT || head_nil_reg) begin
                                l_wd = {head_nil_reg || cmd_reg == CMD_INS_TAIL,
                                        head_reg};
                                head_n = a_fidx; head_nil_n = 1'b0;
                                do_out = 1'b1; state_next = S_OUT;
                            end else begin
                                l_wd = {1'b1, {IW{1'b0}}};
                            end
                        end
                    end
                    CMD_INS_AFTER, CMD_DEL_FRONT, CMD_DEL_TAIL,
                    CMD_DEL_KEY, CMD_READ_OUT: begin
                        if (head_nil_reg) begin
                            do_out = 1'b1; st_set = ST_MISS; state_next = S_OUT;
                        end
                    end
                    default: begin
                        do_out = 1'b1; st_set = ST_MISS; state_next = S_OUT;
                    end
                endcase
            end
            S_WAIT: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                // RAM data for cur_reg is valid here
                state_next = S_WAIT;
                case (cmd_reg)
                    CMD_INS_TAIL: begin
                        if (l_nil || walk_end) begin
                            l_we = 1'b1; l_wa = cur_reg; l_wd = {1'b0, new_reg};
                            do_out = 1'b1; state_next = S_OUT;
                        end else begin
                            cur_n = l_nxt; rd_a = l_nxt; steps_n = steps_reg + 1'b1;
                        end
                    end
                    CMD_INS_AFTER: begin
                        if (hit) begin
                            if (!a_any) begin
                                do_out = 1'b1; st_set = ST_FULL; state_next = S_OUT;
                            end else begin
                                a_take = 1'b1; new_n = a_fidx;
                                v_we = 1'b1; v_wa = a_fidx;
                                l_we = 1'b1; l_wa = a_fidx; l_wd = l_rd;
                                state_next = S_WR1;
                            end
                        end else if (l_nil || walk_end) begin
                            do_out = 1'b1; st_set = ST_MISS; state_next = S_OUT;
                        end else begin
                            cur_n = l_nxt; rd_a = l_nxt; steps_n = steps_reg + 1'b1;
                        end
                    end
                    CMD_DEL_FRONT: begin
                        head_n = l_nxt; head_nil_n = l_nil;
                        a_give = 1'b1; do_out = 1'b1; state_next = S_OUT;
                    end
                    CMD_DEL_TAIL: begin
                        if (l_nil || walk_end) begin
                            if (prev_nil_reg) begin
                                head_nil_n = 1'b1;
                            end else begin
                                l_we = 1'b1; l_wa = prev_reg; l_wd = {1'b1, {IW{1'b0}}};
                            end
                            a_give = 1'b1; do_out = 1'b1; state_next = S_OUT;
                        end else begin
                            prev_n = cur_reg; prev_nil_n = 1'b0;
                            cur_n = l_nxt; rd_a = l_nxt; steps_n = steps_reg + 1'b1;
                        end
                    end
                    CMD_DEL_KEY: begin
                        if (hit) begin
                            if (prev_nil_reg) begin
                                head_n = l_nxt; head_nil_n = l_nil;
                            end else begin
                                l_we = 1'b1; l_wa = prev_reg; l_wd = l_rd;
                            end
                            a_give = 1'b1; do_out = 1'b1; state_next = S_OUT;
                        end else if (l_nil || steps_reg >= CW'(CAPACITY)) begin
                            do_out = 1'b1; st_set = ST_MISS; state_next = S_OUT;
                        end else begin
                            prev_n = cur_reg; prev_nil_n = 1'b0;
                            cur_n = l_nxt; rd_a = l_nxt; steps_n = steps_reg + 1'b1;
                        end
                    end
                    CMD_READ_OUT: begin
                        do_out = 1'b1; state_next = S_EMIT;
                    end
                    default: begin
                        do_out = 1'b1; st_set = ST_MISS; state_next = S_OUT;
                    end
                endcase
            end
            S_WR1: begin
                l_we = 1'b1; l_wa = cur_reg; l_wd = {1'b0, new_reg};
                do_out = 1'b1; state_next = S_OUT;
            end
            S_EMIT: begin
                // hold until the read-out word is taken, then advance
                if (out_fire) begin
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        cur_n = l_nxt; rd_a = l_nxt;
                        cnt_n = cnt_reg + 1'b1; state_next = S_WR2;
                    end
                end else begin
                    rd_a = cur_reg;
                end
            end
            S_WR2: begin
                state_next = S_EVAL;
            end
            S_OUT: begin
                if (out_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic rd_last;
    assign rd_last = l_nil || (cnt_reg >= RW'(MAX_OUT - 1))
                     || (cnt_reg >= RW'(CAPACITY - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_nil_reg <= 1'b1;
            ovalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_nil_reg <= head_nil_n;
            if (out_fire) begin
                ovalid_reg <= 1'b0;
            end
            if (do_out) begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_n; prev_reg <= prev_n; head_reg <= head_n; new_reg <= new_n;
        prev_nil_reg <= prev_nil_n; steps_reg <= steps_n; cnt_reg <= cnt_n;
        if (acc) begin
            cmd_reg <= cmd_t'(s_axis_tdata[2:0]);
            val_reg <= VALUE_BITS'(signed'(s_axis_tdata[34:3]));
            key_reg <= VALUE_BITS'(signed'(s_axis_tdata[66:35]));
        end
        if (do_out) begin
            if (state_reg == S_EVAL && cmd_reg == CMD_READ_OUT) begin
                st_reg   <= ST_DONE;
                item_reg <= 32'(signed'(v_rd));
                last_reg <= rd_last;
            end else begin
                st_reg   <= st_set;
                item_reg <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {6'd0, item_reg, st_reg};
    assign m_axis_tlast  = last_reg;

    no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> !s_axis_tready) else $error("word accepted while busy");
    out_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (state_reg == S_OUT || state_reg == S_EMIT))
        else $error("result shown outside output states");
    single_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !l_we && !v_we) else $error("write while idle");
endmodule
